[rtl/core/trdm_pkg.sv]
// ----------------------------------------------------------------------------
// trdm_pkg
// Shared types, sizes and register codes for the token range delimiter
// matcher.
// ----------------------------------------------------------------------------
package trdm_pkg;

  // sizing
  localparam int MAX_PATTERN_TOKENS = 4;
  localparam int TOKEN_BITS         = 32;
  localparam int MAX_SEQUENCE       = 65536;

  // the register map holds four pattern tokens per pattern
  localparam int REG_TOKENS = 4;
  localparam int LEN_CAP    = (MAX_PATTERN_TOKENS < REG_TOKENS) ? MAX_PATTERN_TOKENS
                                                                 : REG_TOKENS;

  // field widths
  localparam int TOKEN_W  = 32;
  localparam int BEGIN_W  = 16;
  localparam int FINISH_W = 17;
  localparam int LEN_W    = 3;
  localparam int POS_W    = $clog2(MAX_SEQUENCE) + 1;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_START_LO  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_HI  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_END_LO    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_END_HI    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_START_LEN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_END_LEN   = 3'd5;

  typedef logic [MAX_PATTERN_TOKENS-1:0][TOKEN_BITS-1:0] hist_t;
  typedef logic [LEN_CAP-1:0][TOKEN_BITS-1:0]            pat_t;

  typedef struct packed {
    logic [TOKEN_W-1:0] token;
    logic               final_token;
  } in_item_t;

  typedef struct packed {
    logic [BEGIN_W-1:0]  range_begin;
    logic [FINISH_W-1:0] range_finish;
  } out_item_t;

  // decoded configuration seen by the matcher
  typedef struct packed {
    pat_t             start_pat;
    pat_t             end_pat;
    logic [LEN_W-1:0] start_len;
    logic [LEN_W-1:0] end_len;
  } cfg_t;

  // pattern token k must equal the history entry written len-1-k steps ago
  function automatic logic pattern_match(hist_t hist, pat_t pat, logic [LEN_W-1:0] len);
    logic ok;
    ok = 1'b0;
    for (int l = 1; l <= LEN_CAP; l++) begin
      if (len == LEN_W'(l)) begin
        ok = 1'b1;
        for (int k = 0; k < l; k++) begin
          if (hist[l-1-k] != pat[k]) ok = 1'b0;
        end
      end
    end
    return ok;
  endfunction

endpackage

[rtl/core/trdm_cfg.sv]
// ----------------------------------------------------------------------------
// trdm_cfg
// Configuration registers: start/end pattern tokens and pattern lengths,
// with lengths clamped to the supported range.
// ----------------------------------------------------------------------------
module trdm_cfg
  import trdm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  logic [CFG_DATA_W-1:0] start_lo_r, start_hi_r, end_lo_r, end_hi_r;
  logic [LEN_W-1:0]      start_len_r, end_len_r;

  assign cfg_ready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_lo_r  <= '0;
      start_hi_r  <= '0;
      end_lo_r    <= '0;
      end_hi_r    <= '0;
      start_len_r <= LEN_W'(1);
      end_len_r   <= LEN_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_START_LO:  start_lo_r  <= cfg_data;
        CFG_START_HI:  start_hi_r  <= cfg_data;
        CFG_END_LO:    end_lo_r    <= cfg_data;
        CFG_END_HI:    end_hi_r    <= cfg_data;
        CFG_START_LEN: start_len_r <= cfg_data[LEN_W-1:0];
        CFG_END_LEN:   end_len_r   <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // zero length acts as one, long lengths clamp to the cap
  function automatic logic [LEN_W-1:0] eff_len(logic [LEN_W-1:0] len);
    if (len == '0) return LEN_W'(1);
    if (len > LEN_W'(LEN_CAP)) return LEN_W'(LEN_CAP);
    return len;
  endfunction

  // unpack pattern tokens, two per 64-bit word
  always_comb begin
    cfg.start_len = eff_len(start_len_r);
    cfg.end_len   = eff_len(end_len_r);
    for (int k = 0; k < LEN_CAP; k++) begin
      if (k < 2) begin
        cfg.start_pat[k] = start_lo_r[(k%2)*32 +: TOKEN_BITS];
        cfg.end_pat[k]   = end_lo_r[(k%2)*32 +: TOKEN_BITS];
      end else begin
        cfg.start_pat[k] = start_hi_r[(k%2)*32 +: TOKEN_BITS];
        cfg.end_pat[k]   = end_hi_r[(k%2)*32 +: TOKEN_BITS];
      end
    end
  end

endmodule

[rtl/core/trdm_core.sv]
// ----------------------------------------------------------------------------
// trdm_core
// Input register, token history and sequence state; one token per cycle unless
// stalled is matched against the sought start or end pattern; a completed range is handed on.
// ----------------------------------------------------------------------------
module trdm_core
  import trdm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  input  logic      res_free,
  output logic      res_valid,
  output out_item_t res_item
);

  logic             s1_valid_r;
  in_item_t         s1_item_r;
  hist_t            hist_r, hist_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             seek_r, seek_nxt;
  logic [LEN_W-1:0] tsg_r, tsg_nxt, tsg_inc;
  logic [BEGIN_W-1:0] held_r, held_nxt;
  logic             active, start_hit, end_hit, fire;

  // match logic on the registered token
  always_comb begin
    active = pos_r < POS_W'(MAX_SEQUENCE);
    hist_nxt[0] = s1_item_r.token[TOKEN_BITS-1:0];
    for (int i = 1; i < MAX_PATTERN_TOKENS; i++) hist_nxt[i] = hist_r[i-1];
    tsg_inc = (tsg_r < LEN_W'(LEN_CAP)) ? tsg_r + LEN_W'(1) : tsg_r;
    start_hit = active && !seek_r && (tsg_inc >= cfg.start_len) &&
                pattern_match(hist_nxt, cfg.start_pat, cfg.start_len);
    end_hit   = active && seek_r && (tsg_inc >= cfg.end_len) &&
                pattern_match(hist_nxt, cfg.end_pat, cfg.end_len);
  end

  // the item retires unless it holds a range that has nowhere to go
  assign fire     = s1_valid_r && (!end_hit || res_free);
  assign in_stall = s1_valid_r && !fire;

  // next sequence state
  always_comb begin
    pos_nxt  = pos_r;
    seek_nxt = seek_r;
    tsg_nxt  = tsg_r;
    held_nxt = held_r;
    if (active) begin
      pos_nxt = pos_r + POS_W'(1);
      tsg_nxt = tsg_inc;
      if (start_hit) begin
        held_nxt = BEGIN_W'(pos_r + POS_W'(1) - POS_W'(cfg.start_len));
        seek_nxt = 1'b1;
        tsg_nxt  = '0;
      end
      if (end_hit) begin
        seek_nxt = 1'b0;
        tsg_nxt  = '0;
      end
    end
    if (s1_item_r.final_token) begin
      pos_nxt  = '0;
      seek_nxt = 1'b0;
      tsg_nxt  = '0;
      held_nxt = '0;
    end
  end

  // result toward the output register
  assign res_valid             = fire && end_hit;
  assign res_item.range_begin  = held_r;
  assign res_item.range_finish = FINISH_W'(pos_r + POS_W'(1));

  // input register and control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      pos_r      <= '0;
      seek_r     <= 1'b0;
      tsg_r      <= '0;
      held_r     <= '0;
    end else begin
      if (!in_stall) s1_valid_r <= in_valid;
      if (fire) begin
        pos_r  <= pos_nxt;
        seek_r <= seek_nxt;
        tsg_r  <= tsg_nxt;
        held_r <= held_nxt;
      end
    end
  end

  // payload: input token and history
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) s1_item_r <= in_data;
    if (fire && active) hist_r <= hist_nxt;
  end

  // a final token leaves the matcher cleared
  a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
    fire && s1_item_r.final_token |=> pos_r == '0 && !seek_r && tsg_r == '0)
    else $error("sequence state not cleared after final token");

  // ranges only close while an end is being sought
  a_res_needs_seek: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> seek_r)
    else $error("range emitted while seeking start");

  // gate counter stays within the pattern cap
  a_tsg_cap: assert property (@(posedge clk) disable iff (!rst_n)
    tsg_r <= LEN_W'(LEN_CAP))
    else $error("tokens_since_gate above cap");

  // position advances by one per retired token inside a sequence
  a_pos_step: assert property (@(posedge clk) disable iff (!rst_n)
    fire && active && !s1_item_r.final_token |=> pos_r == $past(pos_r) + POS_W'(1))
    else $error("position did not advance");

endmodule

[rtl/core/trdm_out.sv]
// ----------------------------------------------------------------------------
// trdm_out
// Result register: holds one range until the receiver takes it.
// ----------------------------------------------------------------------------
module trdm_out
  import trdm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      res_valid,
  input  out_item_t res_item,
  output logic      res_free,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic      out_valid_r;
  out_item_t out_item_r;

  // free when empty or being drained this cycle
  assign res_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) out_item_r <= res_item;
  end

endmodule

[rtl/core/token_range_delimiter_matcher_top.sv]
// ----------------------------------------------------------------------------
// token_range_delimiter_matcher_top
// Finds start ... end delimiter ranges in a token stream.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   one token per beat with a final_token flag closing the sequence.
//   out_*  one beat per completed range: begin position and end position
//          (exclusive). Ranges never overlap.
//   cfg_*  register writes, always ready; write only while the block is idle.
// Path: a token is held in the input register and the range it closes (if any)
// in the result register, which presents it on out_*.
// Throughput: one token per cycle while in_stall is low; the match against the
// four-entry token history is combinational, so nothing limits the rate but the
// receiver.
// Stall: a held result keeps the output register full; the next token is
// still taken into the input register, and in_stall rises only when that
// token itself closes a range while the output is blocked.
// Reset: patterns clear to zero, lengths to one, sequence state to its
// start; the token history is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module token_range_delimiter_matcher_top
  import trdm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t      cfg;
  logic      res_valid, res_free;
  out_item_t res_item;

  // configuration registers
  trdm_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // matcher
  trdm_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .res_free  (res_free),
    .res_valid (res_valid),
    .res_item  (res_item)
  );

  // result register
  trdm_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_item  (res_item),
    .res_free  (res_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

[bench/tb_token_range_delimiter_matcher_top.sv]
// ----------------------------------------------------------------------------
// tb_token_range_delimiter_matcher_top
// Self-checking bench for the token range delimiter matcher. Token beats go in
// through the stall handshake while a software copy of the matcher tracks
// patterns, token history and positions. Every range beat is compared field by
// field with the oldest predicted range. Directed sequences cover reset
// patterns, length saturation, overlap rules and pattern changes
// mid-sequence. Random sequences built from pattern fragments then run
// under several sender/receiver idle mixes.
// ----------------------------------------------------------------------------
module tb_token_range_delimiter_matcher_top;
  timeunit 1ns;
  timeprecision 1ps;
  import trdm_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 1000000;
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned HOLD_CYCLES   = 300;

  // dut signals, inputs known from time zero
  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // traffic shaping
  int unsigned idle_pct    = 0;
  int unsigned stall_pct   = 0;
  int unsigned hold_reqs   = 0;
  int unsigned holds_done  = 0;
  int unsigned hold_left   = 0;
  int unsigned cycle_count = 0;
  int unsigned error_count = 0;

  // matcher copy: registers
  logic [63:0] start_lo_reg  = '0;
  logic [63:0] start_hi_reg  = '0;
  logic [63:0] end_lo_reg    = '0;
  logic [63:0] end_hi_reg    = '0;
  logic [2:0]  start_len_reg = 3'd1;
  logic [2:0]  end_len_reg   = 3'd1;

  // matcher copy: sequence state
  logic [31:0] seen_tokens [MAX_PATTERN_TOKENS];
  int unsigned next_pos   = 0;
  bit          in_range   = 1'b0;
  int unsigned gate_count = 0;
  logic [15:0] open_begin = '0;

  out_item_t   pending_ranges [$];
  logic [31:0] token_pool [4];

  token_range_delimiter_matcher_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("TEST FAILED");
      $finish;
    end
  end

  // receiver stall, with an occasional long hold
  always @(negedge clk) begin
    if (hold_reqs != holds_done) begin
      hold_left  = HOLD_CYCLES;
      holds_done = hold_reqs;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // range beat check
  always @(posedge clk) begin : check_ranges
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_ranges.size() == 0) begin
        error_count++;
        $display("%0t: unexpected range beat, expected none, actual begin=%0d finish=%0d",
                 $time, out_data.range_begin, out_data.range_finish);
      end else begin
        want = pending_ranges.pop_front();
        if (out_data.range_begin !== want.range_begin) begin
          error_count++;
          $display("%0t: range_begin mismatch, expected %0d actual %0d",
                   $time, want.range_begin, out_data.range_begin);
        end
        if (out_data.range_finish !== want.range_finish) begin
          error_count++;
          $display("%0t: range_finish mismatch, expected %0d actual %0d",
                   $time, want.range_finish, out_data.range_finish);
        end
      end
    end
  end

  // length 0 acts as 1, anything above the cap acts as the cap
  function automatic int unsigned clamp_len(input logic [2:0] len);
    if (len == 3'd0) return 1;
    if (len > LEN_CAP) return LEN_CAP;
    return 32'(len);
  endfunction

  // token k of a pattern held in a low/high register pair
  function automatic logic [31:0] pattern_word(input logic [63:0] lo, input logic [63:0] hi,
                                               input int unsigned k);
    logic [63:0] w;
    w = (k < 2) ? lo : hi;
    return k[0] ? w[63:32] : w[31:0];
  endfunction

  // oldest pattern token lines up with the oldest history entry in use
  function automatic bit history_hit(input logic [63:0] lo, input logic [63:0] hi,
                                     input int unsigned len);
    for (int unsigned k = 0; k < len; k++) begin
      if (seen_tokens[len-1-k] !== pattern_word(lo, hi, k)) return 1'b0;
    end
    return 1'b1;
  endfunction

  // advance the matcher copy by one accepted token, queue the range it closes
  task automatic predict_range(input logic [31:0] tok, input logic fin);
    int unsigned slen;
    int unsigned elen;
    out_item_t   r;
    if (next_pos < MAX_SEQUENCE) begin
      slen = clamp_len(start_len_reg);
      elen = clamp_len(end_len_reg);
      for (int i = MAX_PATTERN_TOKENS - 1; i > 0; i--) seen_tokens[i] = seen_tokens[i-1];
      seen_tokens[0] = tok;
      if (gate_count < LEN_CAP) gate_count++;
      if (!in_range) begin
        if (gate_count >= slen && history_hit(start_lo_reg, start_hi_reg, slen)) begin
          open_begin = 16'(next_pos + 1 - slen);
          in_range   = 1'b1;
          gate_count = 0;
        end
      end else if (gate_count >= elen && history_hit(end_lo_reg, end_hi_reg, elen)) begin
        r.range_begin  = open_begin;
        r.range_finish = 17'(next_pos + 1);
        pending_ranges = {pending_ranges, r};
        in_range   = 1'b0;
        gate_count = 0;
      end
      next_pos++;
    end
    if (fin) begin
      next_pos   = 0;
      in_range   = 1'b0;
      gate_count = 0;
      open_begin = '0;
    end
  endtask

  // one token beat; valid stays high into the next call unless a gap is drawn
  task automatic send_token(input logic [31:0] tok, input logic fin);
    in_item_t beat;
    beat.token       = tok;
    beat.final_token = fin;
    if ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
      while ($urandom_range(0, 99) < idle_pct) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_range(tok, fin);
    @(negedge clk);
  endtask

  // sender quiet until every predicted range has left the block
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_ranges.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // write all six registers back to back
  task automatic write_regs(input logic [63:0] s_lo, input logic [63:0] s_hi,
                            input logic [63:0] e_lo, input logic [63:0] e_hi,
                            input logic [2:0] s_len, input logic [2:0] e_len);
    logic [CFG_IDX_W-1:0] idx [6];
    logic [63:0]          val [6];
    idx = '{CFG_START_LO, CFG_START_HI, CFG_END_LO, CFG_END_HI, CFG_START_LEN, CFG_END_LEN};
    val = '{s_lo, s_hi, e_lo, e_hi, 64'(s_len), 64'(e_len)};
    for (int i = 0; i < 6; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      case (idx[i])
        CFG_START_LO:  start_lo_reg  = val[i];
        CFG_START_HI:  start_hi_reg  = val[i];
        CFG_END_LO:    end_lo_reg    = val[i];
        CFG_END_HI:    end_hi_reg    = val[i];
        CFG_START_LEN: start_len_reg = val[i][2:0];
        CFG_END_LEN:   end_len_reg   = val[i][2:0];
        default: ;
      endcase
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  // reset patterns are a single zero token for both start and end
  task automatic test_reset_patterns();
    send_token(32'h0000_0000, 1'b0);
    send_token(32'hFFFF_FFFF, 1'b0);
    send_token(32'h0000_0000, 1'b1);
    wait_idle();
  endtask

  // four-token start via an over-range length, one-token end via length zero;
  // the final token itself closes the range
  task automatic test_long_patterns();
    write_regs({32'h0000_0000, 32'hFFFF_FFFF}, {32'hAAAA_AAAA, 32'h5555_5555},
               {32'h0000_0000, 32'hFFFF_FFFF}, 64'hFFFF_FFFF_FFFF_FFFF, 3'd7, 3'd0);
    send_token(32'hFFFF_FFFF, 1'b0);
    send_token(32'h0000_0000, 1'b0);
    send_token(32'h5555_5555, 1'b0);
    send_token(32'hAAAA_AAAA, 1'b0);
    send_token(32'hFFFF_FFFF, 1'b1);
    wait_idle();
  endtask

  // end pattern that starts inside the start pattern must not count;
  // a start left open at the final token gives nothing
  task automatic test_no_overlap();
    write_regs({32'h0000_00B2, 32'h0000_00A1}, 64'hFFFF_FFFF_0000_0000,
               {32'h0000_00C3, 32'h0000_00B2}, 64'h0, 3'd2, 3'd2);
    send_token(32'h0000_00A1, 1'b0);
    send_token(32'h0000_00B2, 1'b0);
    send_token(32'h0000_00C3, 1'b0);
    send_token(32'h0000_00B2, 1'b0);
    send_token(32'h0000_00C3, 1'b0);
    send_token(32'h0000_00A1, 1'b0);
    send_token(32'h0000_00B2, 1'b1);
    wait_idle();
  endtask

  // patterns change while a range is open; the new end applies to later tokens
  task automatic test_retune_mid_sequence();
    write_regs({32'h0, 32'h1111_0000}, 64'h0,
               {32'h3333_0000, 32'h2222_0000}, {32'h5555_0000, 32'h4444_0000}, 3'd1, 3'd4);
    send_token(32'h1111_0000, 1'b0);
    send_token(32'h2222_0000, 1'b0);
    send_token(32'h3333_0000, 1'b0);
    wait_idle();
    write_regs({32'h0, 32'h1111_0000}, 64'h0,
               {32'h3333_0000, 32'h2222_0000}, {32'h0, 32'h4444_0000}, 3'd1, 3'd3);
    send_token(32'h4444_0000, 1'b1);
    wait_idle();
  endtask

  // receiver holds off for a long stretch while the sender keeps offering
  task automatic test_backpressure();
    logic [31:0] a_tok;
    a_tok     = $urandom;
    idle_pct  = 0;
    stall_pct = 0;
    write_regs({32'h0, a_tok}, 64'h0, {32'h0, ~a_tok}, 64'h0, 3'd1, 3'd1);
    hold_reqs++;
    for (int i = 0; i < 60; i++) send_token(i[0] ? ~a_tok : a_tok, i == 59);
    wait_idle();
  endtask

  // fresh token pool and patterns drawn from it
  task automatic load_random_setup();
    logic [31:0] sp [4];
    logic [31:0] ep [4];
    int unsigned r;
    foreach (token_pool[i]) begin
      r = $urandom_range(0, 7);
      token_pool[i] = (r == 0) ? 32'h0 : (r == 1) ? 32'hFFFF_FFFF : $urandom;
    end
    foreach (sp[k]) begin
      sp[k] = token_pool[$urandom_range(0, 3)];
      ep[k] = token_pool[$urandom_range(0, 3)];
    end
    write_regs({sp[1], sp[0]}, {sp[3], sp[2]}, {ep[1], ep[0]}, {ep[3], ep[2]},
               3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
  endtask

  // one sequence of pattern pieces, pool tokens and noise, closed by a final beat
  task automatic send_random_sequence(output int unsigned count);
    logic [31:0] toks [$];
    int unsigned target;
    int unsigned r;
    target = $urandom_range(1, 40);
    while (toks.size() < target) begin
      r = $urandom_range(0, 99);
      if (r < 30) begin
        for (int unsigned k = 0; k < clamp_len(start_len_reg); k++)
          toks = {toks, pattern_word(start_lo_reg, start_hi_reg, k)};
      end else if (r < 60) begin
        for (int unsigned k = 0; k < clamp_len(end_len_reg); k++)
          toks = {toks, pattern_word(end_lo_reg, end_hi_reg, k)};
      end else if (r < 92) begin
        toks = {toks, token_pool[$urandom_range(0, 3)]};
      end else begin
        toks = {toks, 32'($urandom)};
      end
    end
    foreach (toks[i]) send_token(toks[i], i == toks.size() - 1);
    count = toks.size();
  endtask

  // random sequences under one idle mix, patterns reloaded every few dozen beats
  task automatic test_random_traffic(input int unsigned send_idle, input int unsigned recv_stall,
                                     input int unsigned n_items);
    int unsigned sent;
    int unsigned block_sent;
    int unsigned n;
    sent      = 0;
    idle_pct  = send_idle;
    stall_pct = recv_stall;
    while (sent < n_items) begin
      load_random_setup();
      block_sent = 0;
      while (block_sent < 60) begin
        send_random_sequence(n);
        block_sent += n;
      end
      sent += block_sent;
      wait_idle();
    end
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    idle_pct  = 34;
    stall_pct = 34;
    test_reset_patterns();
    test_long_patterns();
    test_no_overlap();
    test_retune_mid_sequence();
    test_backpressure();
    test_random_traffic(0, 0, 250);
    test_random_traffic(72, 0, 250);
    test_random_traffic(0, 72, 250);
    test_random_traffic(34, 34, 250);
    wait_idle();
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
